// File: sv/ritt_pkg.sv
// Package: widths, types and sequencer constants for the rectangle ink touch test.
`default_nettype none
package ritt_pkg;

    localparam int COORD_WIDTH = 24;
    // operand: differences and doubled coordinates need two extra bits
    localparam int OPND_WIDTH  = COORD_WIDTH + 2;
    localparam int PROD_WIDTH  = 2 * OPND_WIDTH;
    localparam int ACC_WIDTH   = PROD_WIDTH + 1;

    // four corner determinants then one crossing determinant, two products each
    localparam int NUM_DETS    = 5;
    localparam int NUM_CORNERS = 4;
    localparam int NUM_ISSUE   = 2 * NUM_DETS;
    localparam int ISS_WIDTH   = $clog2(NUM_ISSUE + 1);
    localparam int DET_WIDTH   = $clog2(NUM_DETS);
    localparam int CNT_WIDTH   = $clog2(NUM_CORNERS + 1);

    localparam logic [DET_WIDTH-1:0] CROSS_DET = DET_WIDTH'(NUM_DETS - 1);

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [OPND_WIDTH-1:0]  t_opnd;
    typedef logic signed [PROD_WIDTH-1:0]  t_prod;
    typedef logic signed [ACC_WIDTH-1:0]   t_acc;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    // one multiply pass: first product loads, second is subtracted
    typedef struct packed {
        logic  issue;
        logic  sub;
        t_opnd a;
        t_opnd b;
    } t_mul_req;

    // sign of a*b - c*d
    typedef struct packed {
        logic valid;
        logic neg;
        logic zero;
    } t_mul_res;

endpackage
`default_nettype wire

// File: sv/ritt_in_if.sv
// Interface: edge input channel with valid/ready handshake.
`default_nettype none
interface ritt_in_if;
    logic             valid;
    logic             ready;
    ritt_pkg::t_coord rect_min_x;
    ritt_pkg::t_coord rect_min_y;
    ritt_pkg::t_coord rect_max_x;
    ritt_pkg::t_coord rect_max_y;
    ritt_pkg::t_coord edge_start_x;
    ritt_pkg::t_coord edge_start_y;
    ritt_pkg::t_coord edge_end_x;
    ritt_pkg::t_coord edge_end_y;
    logic             last_edge;

    modport source (
        output valid, rect_min_x, rect_min_y, rect_max_x, rect_max_y,
               edge_start_x, edge_start_y, edge_end_x, edge_end_y, last_edge,
        input  ready
    );
    modport sink (
        input  valid, rect_min_x, rect_min_y, rect_max_x, rect_max_y,
               edge_start_x, edge_start_y, edge_end_x, edge_end_y, last_edge,
        output ready
    );
endinterface
`default_nettype wire

// File: sv/ritt_out_if.sv
// Interface: result output channel with valid/ready handshake.
`default_nettype none
interface ritt_out_if;
    logic valid;
    logic ready;
    logic touches_ink;
    logic edge_crossed;
    logic center_inside;

    modport source (
        output valid, touches_ink, edge_crossed, center_inside,
        input  ready
    );
    modport sink (
        input  valid, touches_ink, edge_crossed, center_inside,
        output ready
    );
endinterface
`default_nettype wire

// File: sv/ritt_det_unit.sv
// Shared multiply/subtract unit: sign of a*b - c*d over two passes.
`default_nettype none
module ritt_det_unit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ritt_pkg::t_mul_req i_req,
    output ritt_pkg::t_mul_res    o_res
);

    logic            r_p_valid;
    logic            r_p_sub;
    ritt_pkg::t_prod r_prod;
    ritt_pkg::t_acc  r_acc;
    logic            r_done;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_p_sub   <= 1'b0;
        end else begin
            r_p_valid <= i_req.issue;
            r_p_sub   <= i_req.sub;
        end
        r_prod <= i_req.a * i_req.b;
    end

    // accumulate stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_p_valid && r_p_sub;
        end
        if (r_p_valid) begin
            if (r_p_sub) begin
                r_acc <= r_acc - ritt_pkg::t_acc'(r_prod);
            end else begin
                r_acc <= ritt_pkg::t_acc'(r_prod);
            end
        end
    end

    assign o_res.valid = r_done;
    assign o_res.neg   = r_acc[ritt_pkg::ACC_WIDTH-1];
    assign o_res.zero  = (r_acc == '0);

    a_done_after_sub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_valid && r_p_sub) |=> r_done)
        else $error("det unit: completed pair not flagged");
    a_done_needs_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(i_req.issue, 2) && $past(i_req.sub, 2))
        else $error("det unit: result without a subtract pass");
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.issue && i_req.sub) |-> $past(i_req.issue) && !$past(i_req.sub))
        else $error("det unit: subtract pass without load pass");

endmodule
`default_nettype wire

// File: sv/rect_ink_touch_test.sv
// Top level: rectangle vs. filled-ink test, clip and even-odd crossing per edge beat.
// Throughput: an edge beat holds ready low until its crossing determinant is done, so the next
//   edge is accepted only after ten passes through the one shared multiplier and its
//   two-stage pipeline, once the sequencer is back in the idle state.
// A last-edge beat passes through the emit state to load the output register, which can stall
//   while a previous result is untaken; the result then waits there while the next query is accepted.
// Reset (synchronous, active low) clears hit and parity state and the output valid flag.
`default_nettype none
module rect_ink_touch_test (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ritt_in_if.sink   i_edge,
    ritt_out_if.source o_result
);

    ritt_pkg::t_state r_state;
    logic [ritt_pkg::ISS_WIDTH-1:0] r_iss;
    logic [ritt_pkg::DET_WIDTH-1:0] r_res;
    logic [ritt_pkg::CNT_WIDTH-1:0] r_pos, r_neg;
    logic r_hit, r_par, r_last;
    logic r_out_valid, r_out_touch, r_out_cross, r_out_inside;
    ritt_pkg::t_coord r_rx0, r_ry0, r_rx1, r_ry1, r_x0, r_y0, r_x1, r_y1;

    ritt_pkg::t_mul_req req;
    ritt_pkg::t_mul_res res;

    ritt_pkg::t_opnd dx, dy, cx2, cy2, x0d, y0d, y1d, cx, cy;
    logic [ritt_pkg::DET_WIDTH-1:0] det_idx;
    logic in_acc, out_acc, finish, emit_go;
    logic touch, flip, inverted, box_miss, degen, corners_split, straddle;
    ritt_pkg::t_coord minx, maxx, miny, maxy;

    assign in_acc  = i_edge.valid && i_edge.ready;
    assign out_acc = o_result.valid && o_result.ready;
    assign i_edge.ready = (r_state == ritt_pkg::ST_IDLE);

    // operands from captured edge
    assign dx  = ritt_pkg::t_opnd'(r_x1) - ritt_pkg::t_opnd'(r_x0);
    assign dy  = ritt_pkg::t_opnd'(r_y1) - ritt_pkg::t_opnd'(r_y0);
    assign cx2 = ritt_pkg::t_opnd'(r_rx0) + ritt_pkg::t_opnd'(r_rx1);
    assign cy2 = ritt_pkg::t_opnd'(r_ry0) + ritt_pkg::t_opnd'(r_ry1);
    assign x0d = ritt_pkg::t_opnd'(r_x0) <<< 1;
    assign y0d = ritt_pkg::t_opnd'(r_y0) <<< 1;
    assign y1d = ritt_pkg::t_opnd'(r_y1) <<< 1;

    assign det_idx = r_iss[ritt_pkg::DET_WIDTH:1];
    assign cx = det_idx[0] ? ritt_pkg::t_opnd'(r_rx1) : ritt_pkg::t_opnd'(r_rx0);
    assign cy = det_idx[1] ? ritt_pkg::t_opnd'(r_ry1) : ritt_pkg::t_opnd'(r_ry0);

    always_comb begin
        req.issue = (r_state == ritt_pkg::ST_RUN) &&
                    (r_iss != ritt_pkg::ISS_WIDTH'(ritt_pkg::NUM_ISSUE));
        req.sub   = r_iss[0];
        if (det_idx == ritt_pkg::CROSS_DET) begin
            // (2x0 - cx2)*dy - dx*(2y0 - cy2)
            req.a = r_iss[0] ? dx : (x0d - cx2);
            req.b = r_iss[0] ? (y0d - cy2) : dy;
        end else begin
            // dx*(cy - y0) - dy*(cx - x0)
            req.a = r_iss[0] ? dy : dx;
            req.b = r_iss[0] ? (cx - ritt_pkg::t_opnd'(r_x0))
                             : (cy - ritt_pkg::t_opnd'(r_y0));
        end
    end

    ritt_det_unit u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_res   (res)
    );

    // edge decision once the crossing determinant arrives
    assign minx = (r_x0 < r_x1) ? r_x0 : r_x1;
    assign maxx = (r_x0 > r_x1) ? r_x0 : r_x1;
    assign miny = (r_y0 < r_y1) ? r_y0 : r_y1;
    assign maxy = (r_y0 > r_y1) ? r_y0 : r_y1;
    assign inverted = (r_rx0 > r_rx1) || (r_ry0 > r_ry1);
    assign box_miss = (minx > r_rx1) || (maxx < r_rx0) || (miny > r_ry1) || (maxy < r_ry0);
    assign degen    = (dx == '0) && (dy == '0);
    assign corners_split = (r_pos != ritt_pkg::CNT_WIDTH'(ritt_pkg::NUM_CORNERS)) &&
                           (r_neg != ritt_pkg::CNT_WIDTH'(ritt_pkg::NUM_CORNERS));
    assign touch    = !inverted && !box_miss && (degen || corners_split);
    assign straddle = (y0d > cy2) != (y1d > cy2);
    assign flip     = straddle && ((dy > 0) ? (!res.neg && !res.zero) : res.neg);

    assign finish  = res.valid && (r_res == ritt_pkg::CROSS_DET);
    assign emit_go = (r_state == ritt_pkg::ST_EMIT) && (!r_out_valid || o_result.ready);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rx0  <= i_edge.rect_min_x;
            r_ry0  <= i_edge.rect_min_y;
            r_rx1  <= i_edge.rect_max_x;
            r_ry1  <= i_edge.rect_max_y;
            r_x0   <= i_edge.edge_start_x;
            r_y0   <= i_edge.edge_start_y;
            r_x1   <= i_edge.edge_end_x;
            r_y1   <= i_edge.edge_end_y;
        end
        if (emit_go) begin
            r_out_touch  <= r_hit || r_par;
            r_out_cross  <= r_hit;
            r_out_inside <= r_par;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ritt_pkg::ST_IDLE;
            r_iss       <= '0;
            r_res       <= '0;
            r_pos       <= '0;
            r_neg       <= '0;
            r_hit       <= 1'b0;
            r_par       <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result reloading the register keeps it valid
            if (out_acc && !emit_go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ritt_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        r_state <= ritt_pkg::ST_RUN;
                        r_last  <= i_edge.last_edge;
                        r_iss   <= '0;
                        r_res   <= '0;
                        r_pos   <= '0;
                        r_neg   <= '0;
                    end
                end
                ritt_pkg::ST_RUN: begin
                    if (req.issue) begin
                        r_iss <= r_iss + 1'b1;
                    end
                    if (res.valid) begin
                        r_res <= r_res + 1'b1;
                        if (r_res != ritt_pkg::CROSS_DET) begin
                            if (res.neg) begin
                                r_neg <= r_neg + 1'b1;
                            end else if (!res.zero) begin
                                r_pos <= r_pos + 1'b1;
                            end
                        end
                    end
                    if (finish) begin
                        r_hit   <= r_hit || touch;
                        r_par   <= r_par ^ flip;
                        r_state <= r_last ? ritt_pkg::ST_EMIT : ritt_pkg::ST_IDLE;
                    end
                end
                ritt_pkg::ST_EMIT: begin
                    if (emit_go) begin
                        r_out_valid <= 1'b1;
                        r_hit       <= 1'b0;
                        r_par       <= 1'b0;
                        r_state     <= ritt_pkg::ST_IDLE;
                    end
                end
                default: r_state <= ritt_pkg::ST_IDLE;
            endcase
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.touches_ink   = r_out_touch;
    assign o_result.edge_crossed  = r_out_cross;
    assign o_result.center_inside = r_out_inside;

    a_iss_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iss <= ritt_pkg::ISS_WIDTH'(ritt_pkg::NUM_ISSUE))
        else $error("issue counter overran");
    a_res_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> (r_state == ritt_pkg::ST_RUN))
        else $error("det result outside of run state");
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ritt_pkg::ST_RUN) && (r_iss == '0) && (r_res == '0))
        else $error("accepted beat did not start a run");
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_go |=> r_out_valid && !r_hit && !r_par)
        else $error("emit did not load output and clear state");

endmodule
`default_nettype wire

// File: tb/rect_ink_touch_test_tb.sv
// Testbench for rect_ink_touch_test: random contour queries, scoreboard checks every verdict.
`timescale 1ns / 100ps

typedef struct {
    ritt_pkg::t_coord min_x;
    ritt_pkg::t_coord min_y;
    ritt_pkg::t_coord max_x;
    ritt_pkg::t_coord max_y;
} t_rect;

typedef struct {
    t_rect            r;
    ritt_pkg::t_coord x0;
    ritt_pkg::t_coord y0;
    ritt_pkg::t_coord x1;
    ritt_pkg::t_coord y1;
    bit               last;
} t_edge;

typedef struct {
    bit touches_ink;
    bit edge_crossed;
    bit center_inside;
} t_verdict;

class ink_scoreboard;
    bit       hit_seen;
    bit       parity;
    t_verdict verdicts[$];
    int       errors;

    // closed segment vs closed rectangle; inverted rectangle holds nothing
    function bit edge_hits(t_edge e);
        longint x0, y0, x1, y1, rx0, ry0, rx1, ry1, dx, dy, cx, cy, d;
        int     pos, neg;
        x0 = e.x0; y0 = e.y0; x1 = e.x1; y1 = e.y1;
        rx0 = e.r.min_x; ry0 = e.r.min_y; rx1 = e.r.max_x; ry1 = e.r.max_y;
        pos = 0;
        neg = 0;
        if (rx0 > rx1 || ry0 > ry1) return 1'b0;
        if ((x0 < x1 ? x0 : x1) > rx1 || (x0 > x1 ? x0 : x1) < rx0) return 1'b0;
        if ((y0 < y1 ? y0 : y1) > ry1 || (y0 > y1 ? y0 : y1) < ry0) return 1'b0;
        dx = x1 - x0;
        dy = y1 - y0;
        if (dx == 0 && dy == 0) return 1'b1;
        for (int k = 0; k < 4; k++) begin
            cx = k[0] ? rx1 : rx0;
            cy = k[1] ? ry1 : ry0;
            d  = dx * (cy - y0) - dy * (cx - x0);
            if (d > 0) pos++;
            else if (d < 0) neg++;
        end
        // all four corners strictly on one side of the edge's line: no contact
        return !(pos == 4 || neg == 4);
    endfunction

    // crossing of the centre row strictly right of the centre, all at double scale
    function bit edge_crosses(t_edge e);
        longint x0, y0, x1, y1, cx2, cy2, dx, dy, s;
        x0 = e.x0; y0 = e.y0; x1 = e.x1; y1 = e.y1;
        cx2 = longint'(e.r.min_x) + longint'(e.r.max_x);
        cy2 = longint'(e.r.min_y) + longint'(e.r.max_y);
        if ((2 * y0 > cy2) == (2 * y1 > cy2)) return 1'b0;
        dx = x1 - x0;
        dy = y1 - y0;
        s  = (2 * x0 - cx2) * dy - dx * (2 * y0 - cy2);
        return dy > 0 ? s > 0 : s < 0;
    endfunction

    function void note_edge(t_edge e);
        t_verdict v;
        if (edge_hits(e)) hit_seen = 1'b1;
        if (edge_crosses(e)) parity = ~parity;
        if (e.last) begin
            v.touches_ink   = hit_seen | parity;
            v.edge_crossed  = hit_seen;
            v.center_inside = parity;
            verdicts.insert(verdicts.size(), v);
            hit_seen = 1'b0;
            parity   = 1'b0;
        end
    endfunction

    function void mismatch(string field, bit want, bit got);
        errors++;
        $display("%0t ERROR %s expected %0b actual %0b", $time, field, want, got);
    endfunction

    function void check_verdict(bit touches, bit crossed, bit inner);
        t_verdict v;
        if (verdicts.size() == 0) begin
            errors++;
            $display("%0t ERROR result beat %0b%0b%0b with nothing outstanding",
                     $time, touches, crossed, inner);
            return;
        end
        v = verdicts.pop_front();
        if (touches != v.touches_ink) mismatch("touches_ink", v.touches_ink, touches);
        if (crossed != v.edge_crossed) mismatch("edge_crossed", v.edge_crossed, crossed);
        if (inner != v.center_inside) mismatch("center_inside", v.center_inside, inner);
    endfunction
endclass

module rect_ink_touch_test_tb;

    localparam int CMIN        = -8388608;
    localparam int CMAX        = 8388607;
    localparam int IDLE_LIMIT  = 3000;
    localparam int LONG_HOLD   = 600;
    localparam int TAIL_CYCLES = 40;
    localparam int EDGE_TARGET = 1800;

    logic i_clk;
    logic i_rst_n;

    ritt_in_if  edge_if ();
    ritt_out_if res_if ();

    rect_ink_touch_test i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_edge   (edge_if),
        .o_result (res_if)
    );

    ink_scoreboard sb = new();

    int edges_sent = 0;
    int tx_run     = 0;
    bit tx_calm    = 1'b0;
    int rx_run     = 0;
    bit rx_calm    = 1'b0;
    bit hold_req   = 1'b0;
    int idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog: cycles without a beat on either channel
    initial begin
        forever begin
            @(posedge i_clk);
            if ((edge_if.valid && edge_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t ERROR timeout, no beat for %0d cycles", $time, idle_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic t_edge make_edge(int rx0, int ry0, int rx1, int ry1,
                                        int x0, int y0, int x1, int y1, bit last);
        t_edge e;
        e.r.min_x = ritt_pkg::t_coord'(rx0);
        e.r.min_y = ritt_pkg::t_coord'(ry0);
        e.r.max_x = ritt_pkg::t_coord'(rx1);
        e.r.max_y = ritt_pkg::t_coord'(ry1);
        e.x0      = ritt_pkg::t_coord'(x0);
        e.y0      = ritt_pkg::t_coord'(y0);
        e.x1      = ritt_pkg::t_coord'(x1);
        e.y1      = ritt_pkg::t_coord'(y1);
        e.last    = last;
        return e;
    endfunction

    function automatic int near(int base, int span);
        return base + int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int rand_base(int span);
        return int'($urandom_range(0, 16777215 - 2 * span)) + CMIN + span;
    endfunction

    // vertex coordinate, often snapped to the rectangle sides or centre
    function automatic int pick_coord(int base, int span, int lo, int hi, int mid);
        case ($urandom_range(0, 11))
            0:       return lo;
            1:       return hi;
            2:       return mid;
            3:       return lo - 1;
            4:       return hi + 1;
            default: return near(base, span);
        endcase
    endfunction

    task automatic send_edge(t_edge e);
        int gap;
        if (tx_run == 0) begin
            tx_run  = $urandom_range(8, 60);
            tx_calm = ($urandom_range(0, 3) == 0);
        end
        tx_run--;
        gap = tx_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            edge_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        edge_if.valid        <= 1'b1;
        edge_if.rect_min_x   <= e.r.min_x;
        edge_if.rect_min_y   <= e.r.min_y;
        edge_if.rect_max_x   <= e.r.max_x;
        edge_if.rect_max_y   <= e.r.max_y;
        edge_if.edge_start_x <= e.x0;
        edge_if.edge_start_y <= e.y0;
        edge_if.edge_end_x   <= e.x1;
        edge_if.edge_end_y   <= e.y1;
        edge_if.last_edge    <= e.last;
        do @(posedge i_clk); while (!edge_if.ready);
        sb.note_edge(e);
        edges_sent++;
    endtask

    task automatic put(int rx0, int ry0, int rx1, int ry1,
                       int x0, int y0, int x1, int y1, bit last);
        send_edge(make_edge(rx0, ry0, rx1, ry1, x0, y0, x1, y1, last));
    endtask

    // stop offering and wait until every verdict has come back
    task automatic drain();
        edge_if.valid <= 1'b0;
        while (sb.verdicts.size() != 0) @(posedge i_clk);
    endtask

    // one query: closed contours in a window, or noise, broken contours,
    // inverted rectangles and a rectangle that changes within the query
    task automatic run_query();
        int    kind, span, bx, by, rx0, ry0, rx1, ry1, cxm, cym, tmp, ncont, nv;
        int    vx[8];
        int    vy[8];
        t_edge plan[$];
        kind = $urandom_range(0, 19);
        case ($urandom_range(0, 3))
            0:       span = 8;
            1:       span = 200;
            2:       span = 5000;
            default: span = 1000000;
        endcase
        bx  = rand_base(span);
        by  = rand_base(span);
        rx0 = near(bx, span);
        rx1 = near(bx, span);
        ry0 = near(by, span);
        ry1 = near(by, span);
        if (rx0 > rx1) begin tmp = rx0; rx0 = rx1; rx1 = tmp; end
        if (ry0 > ry1) begin tmp = ry0; ry0 = ry1; ry1 = tmp; end
        if ($urandom_range(0, 15) == 0) rx1 = rx0;
        if ($urandom_range(0, 15) == 0) ry1 = ry0;
        if (kind == 1) begin
            if ($urandom_range(0, 1)) begin tmp = rx0; rx0 = rx1; rx1 = tmp; end
            else begin tmp = ry0; ry0 = ry1; ry1 = tmp; end
        end
        cxm = (rx0 + rx1) >>> 1;
        cym = (ry0 + ry1) >>> 1;
        if (kind == 0) begin
            repeat ($urandom_range(1, 4))
                plan.insert(plan.size(), make_edge($urandom, $urandom, $urandom, $urandom,
                                                   $urandom, $urandom, $urandom, $urandom,
                                                   1'b0));
        end else begin
            ncont = $urandom_range(1, 3);
            repeat (ncont) begin
                nv = $urandom_range(3, 7);
                for (int i = 0; i < nv; i++) begin
                    vx[i] = pick_coord(bx, span, rx0, rx1, cxm);
                    vy[i] = pick_coord(by, span, ry0, ry1, cym);
                    if (i > 0 && $urandom_range(0, 7) == 0) vy[i] = vy[i-1];
                    if (i > 0 && $urandom_range(0, 9) == 0) begin
                        vx[i] = vx[i-1];
                        vy[i] = vy[i-1];
                    end
                end
                for (int i = 0; i < nv; i++) begin
                    if (kind == 2 && i == nv - 1) continue;
                    if (kind == 3 && i[0])
                        plan.insert(plan.size(), make_edge(cxm, cym, rx1, ry1, vx[i], vy[i],
                                                           vx[(i+1)%nv], vy[(i+1)%nv], 1'b0));
                    else
                        plan.insert(plan.size(), make_edge(rx0, ry0, rx1, ry1, vx[i], vy[i],
                                                           vx[(i+1)%nv], vy[(i+1)%nv], 1'b0));
                end
            end
        end
        plan[$].last = 1'b1;
        foreach (plan[i]) send_edge(plan[i]);
    endtask

    // result side: random stalls, calm stretches, and one long hold-off on request
    initial begin : result_sink
        int stall;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (rx_run == 0) begin
                rx_run  = $urandom_range(4, 30);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            rx_run--;
            stall = rx_calm ? 0 : $urandom_range(0, 11);
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = LONG_HOLD;
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            sb.check_verdict(res_if.touches_ink, res_if.edge_crossed, res_if.center_inside);
        end
    end

    initial begin : stimulus
        int nq;
        i_rst_n              <= 1'b0;
        edge_if.valid        <= 1'b0;
        edge_if.rect_min_x   <= '0;
        edge_if.rect_min_y   <= '0;
        edge_if.rect_max_x   <= '0;
        edge_if.rect_max_y   <= '0;
        edge_if.edge_start_x <= '0;
        edge_if.edge_start_y <= '0;
        edge_if.edge_end_x   <= '0;
        edge_if.edge_end_y   <= '0;
        edge_if.last_edge    <= 1'b0;
        res_if.ready         <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: point edges, field extremes, inverted box, centre row, closures
        put(0, 0, 100, 100, 50, 50, 50, 50, 1'b1);
        put(0, 0, 100, 100, 200, 50, 200, 50, 1'b1);
        put(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, 1'b1);
        put(0, 0, 100, 100, CMAX, CMAX, CMAX, CMIN, 1'b1);
        put(0, 0, 100, 100, CMIN, CMAX, CMIN, CMIN, 1'b1);
        put(100, 0, -100, 100, 10, -50, 10, 150, 1'b1);
        put(0, 0, 100, 100, 60, 50, 200, 50, 1'b1);
        put(0, 0, 100, 100, 60, 60, 200, 60, 1'b0);
        put(0, 0, 100, 100, 200, 60, 200, 40, 1'b1);
        // square around the rectangle: inside by parity, no edge contact
        put(0, 0, 100, 100, -50, -50, 150, -50, 1'b0);
        put(0, 0, 100, 100, 150, -50, 150, 150, 1'b0);
        put(0, 0, 100, 100, 150, 150, -50, 150, 1'b0);
        put(0, 0, 100, 100, -50, 150, -50, -50, 1'b1);
        put(0, 0, 100, 100, 200, 200, 300, 300, 1'b0);
        put(250, 250, 350, 350, 200, 200, 300, 300, 1'b1);
        put(0, 0, 100, 100, 100, 100, 150, 150, 1'b1);
        put(0, 0, 100, 100, 101, 100, 100, 101, 1'b1);
        put(0, 0, 100, 100, -10, -10, -10, 200, 1'b1);
        drain();

        nq = 0;
        while (edges_sent < EDGE_TARGET) begin
            if (nq == 3 || nq == 90) hold_req = 1'b1;
            if (nq % 25 == 24) drain();
            run_query();
            nq++;
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.verdicts.size() == 0) begin
            $display("PASS");
        end else begin
            if (sb.verdicts.size() != 0)
                $display("%0t ERROR %0d verdicts never arrived", $time, sb.verdicts.size());
            $display("FAIL");
        end
        $finish;
    end

endmodule
